@@ rtl/wfms_pkg.sv @@
// Shared constants and elaboration-time trig helpers for the windowed FFT magnitude block.
package wfms_pkg;

    localparam int ROOT_BITS = 32;
    localparam int RAD_BITS  = 64;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint HAM_A_Q30  = 64'sd579820585;
    localparam longint HAM_B_Q30  = 64'sd493921239;

    typedef struct packed {
        longint c;
        longint s;
    } t_cs;

    // One Taylor term step: divide by (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
    function automatic longint f_div_term(longint t, int k, bit want_sin);
        longint r;
        r = t;
        case (k)
            1:  r = want_sin ? t / 6   : t / 2;
            2:  r = want_sin ? t / 20  : t / 12;
            3:  r = want_sin ? t / 42  : t / 30;
            4:  r = want_sin ? t / 72  : t / 56;
            5:  r = want_sin ? t / 110 : t / 90;
            6:  r = want_sin ? t / 156 : t / 132;
            7:  r = want_sin ? t / 210 : t / 182;
            8:  r = want_sin ? t / 272 : t / 240;
            9:  r = want_sin ? t / 342 : t / 306;
            10: r = want_sin ? t / 420 : t / 380;
            default: r = t;
        endcase
        return r;
    endfunction

    // cos or sin in Q30 for theta in [0, pi/2], Q30 in.
    function automatic longint f_series(longint th, bit want_sin);
        longint x2;
        longint term;
        longint sum;
        x2   = (th * th) >> 30;
        term = want_sin ? th : (64'sd1 <<< 30);
        sum  = term;
        for (int k = 1; k <= 10; k++) begin
            term = f_div_term((term * x2) >> 30, k, want_sin);
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // cos and sin in Q30 of a 32-bit turn fraction.
    function automatic t_cs f_cos_sin(longint p);
        longint q;
        longint th;
        longint c0;
        longint s0;
        t_cs    r;
        q  = (p >> 30) & 64'sd3;
        th = ((p & 64'sh3FFF_FFFF) * TWO_PI_Q30) >> 32;
        c0 = f_series(th, 1'b0);
        s0 = f_series(th, 1'b1);
        case (q)
            64'sd0:  begin r.c = c0;  r.s = s0;  end
            64'sd1:  begin r.c = -s0; r.s = c0;  end
            64'sd2:  begin r.c = -c0; r.s = -s0; end
            default: begin r.c = s0;  r.s = -c0; end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/windowed_fft_magnitude_spectrum_top.sv @@
// Top level of the Hamming-windowed real FFT magnitude spectrum block.
//
// Usage: each stereo word on the s_ channel (left in the low half of s_tdata,
// right above it) is mixed to mono (average, or left only when register 0
// bit 0 is set) and written into a ring of FFT_POINTS samples. The whole ring
// is then windowed in stored order, transformed by an in-place radix-2 FFT and
// reduced to FFT_POINTS/2+1 bin magnitudes, sent on the m_ channel as groups
// of three bins; m_tlast marks the final group.
// Datapath: one shared multiplier does all products. Windowing takes one
// product per point, each butterfly four products and two writes through the
// single work-memory write port, each bin two squares and a 32-step square
// root. Work also waits while the receiver stalls.
// s_tready is high only while idle; one word is worked at a time.
// Reset: a clearing pass writes zero to every ring entry, with s_tready low;
// configuration writes are taken throughout.
// Stall: a finished group holds on m_tdata until m_tready; work waits.
module windowed_fft_magnitude_spectrum_top #(
    parameter int FFT_POINTS  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // s_tdata: left_sample, right_sample (from bit 0 up)
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // m_tdata: first_bin[6:0], magnitude_a, magnitude_b, magnitude_c
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [55:0]                            m_tdata,
    output logic                                   m_tlast,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int LOG2N      = $clog2(FFT_POINTS);
    localparam int SW         = $clog2(LOG2N);
    localparam int CW         = LOG2N + 1;
    localparam int NUM_BINS   = FFT_POINTS / 2 + 1;
    localparam int NUM_GROUPS = (NUM_BINS + 2) / 3;
    localparam int SLOTS_END  = 3 * NUM_GROUPS;
    localparam int WW         = SAMPLE_BITS + LOG2N + 1;
    localparam int MW         = (WW > 30) ? WW : 30;
    localparam int PW         = 2 * MW;
    localparam int DOWN       = (SAMPLE_BITS >= 14) ? SAMPLE_BITS - 14 : 0;
    localparam int UP         = (SAMPLE_BITS < 14) ? 14 - SAMPLE_BITS : 0;
    localparam int SH         = LOG2N + DOWN;
    localparam longint WIN_DEN   = FFT_POINTS - 1;
    localparam longint MAG_CLAMP = 64'sd1 <<< 28;

    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_LRD  = 5'd2;
    localparam logic [4:0] ST_LMUL = 5'd3;
    localparam logic [4:0] ST_LWR  = 5'd4;
    localparam logic [4:0] ST_BRD  = 5'd5;
    localparam logic [4:0] ST_BM0  = 5'd6;
    localparam logic [4:0] ST_BM1  = 5'd7;
    localparam logic [4:0] ST_BM2  = 5'd8;
    localparam logic [4:0] ST_BM3  = 5'd9;
    localparam logic [4:0] ST_BWA  = 5'd10;
    localparam logic [4:0] ST_BWB  = 5'd11;
    localparam logic [4:0] ST_MRD  = 5'd12;
    localparam logic [4:0] ST_MRE  = 5'd13;
    localparam logic [4:0] ST_MIM  = 5'd14;
    localparam logic [4:0] ST_MSQ  = 5'd15;
    localparam logic [4:0] ST_MOUT = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;

    localparam logic [0:0] REG_MONO_MODE = 1'b0;

    typedef logic signed [16:0] t_win_tab [FFT_POINTS];
    typedef logic signed [16:0] t_tw_tab  [FFT_POINTS/2];

    // Hamming window in Q15, symmetric over FFT_POINTS-1 intervals.
    function automatic t_win_tab f_win_tab();
        t_win_tab       tab;
        wfms_pkg::t_cs  cs;
        longint         p;
        longint         v;
        for (int i = 0; i < FFT_POINTS; i++) begin
            p  = ((longint'(i) <<< 32) / WIN_DEN) & 64'shFFFF_FFFF;
            cs = wfms_pkg::f_cos_sin(p);
            v  = wfms_pkg::HAM_A_Q30 * (64'sd1 <<< 30) - wfms_pkg::HAM_B_Q30 * cs.c;
            tab[i] = 17'((v + (64'sd1 <<< 44)) >>> 45);
        end
        return tab;
    endfunction

    // Twiddles in Q15: cosine or sine of 2*pi*k/FFT_POINTS.
    function automatic t_tw_tab f_tw_tab(bit want_sin);
        t_tw_tab        tab;
        wfms_pkg::t_cs  cs;
        longint         p;
        for (int i = 0; i < FFT_POINTS / 2; i++) begin
            p  = (longint'(i) <<< (32 - LOG2N)) & 64'shFFFF_FFFF;
            cs = wfms_pkg::f_cos_sin(p);
            tab[i] = want_sin ? 17'((cs.s + 64'sd16384) >>> 15)
                              : 17'((cs.c + 64'sd16384) >>> 15);
        end
        return tab;
    endfunction

    localparam t_win_tab WIN_TAB = f_win_tab();
    localparam t_tw_tab  TW_COS  = f_tw_tab(1'b0);
    localparam t_tw_tab  TW_SIN  = f_tw_tab(1'b1);

    localparam logic signed [PW-1:0] RND_HALF = PW'(16384);

    // control
    logic [4:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [LOG2N-1:0]  r_wp, n_wp;
    logic [SW-1:0]     r_stage, n_stage;
    logic [LOG2N-2:0]  r_bf, n_bf;
    logic [1:0]        r_slot, n_slot;
    logic              r_mono;

    // memories
    logic [SAMPLE_BITS-1:0] r_ring [FFT_POINTS];
    logic [2*WW-1:0]        r_work [FFT_POINTS];
    logic signed [SAMPLE_BITS-1:0] r_ring_q;
    logic [2*WW-1:0]        r_rd_a;
    logic [2*WW-1:0]        r_rd_b;

    // datapath
    logic signed [PW-1:0]   r_acc;
    logic signed [WW-1:0]   r_tr;
    logic signed [WW-1:0]   r_ti;
    logic [15:0]            r_mag0;
    logic [15:0]            r_mag1;
    logic [55:0]            r_mout;
    logic                   r_last;

    logic                   in_acc;
    logic                   ring_we;
    logic [LOG2N-1:0]       ring_wa;
    logic [SAMPLE_BITS-1:0] ring_wd;
    logic signed [SAMPLE_BITS-1:0] left_s;
    logic signed [SAMPLE_BITS-1:0] right_s;
    logic signed [SAMPLE_BITS:0]   mix_sum;
    logic [SAMPLE_BITS-1:0] mono_s;

    logic                   work_we;
    logic [LOG2N-1:0]       work_wa;
    logic [2*WW-1:0]        work_wd;
    logic [LOG2N-1:0]       rd_addr_a;
    logic [LOG2N-1:0]       load_addr;
    logic [LOG2N-2:0]       hm;
    logic [LOG2N-2:0]       kk;
    logic [LOG2N-1:0]       bf_a;
    logic [LOG2N-1:0]       bf_b;
    logic [LOG2N-2:0]       tw_idx;
    logic signed [16:0]     wc;
    logic signed [16:0]     ws;
    logic signed [WW-1:0]   re_a, im_a, re_b, im_b;
    logic signed [MW-1:0]   re_c, im_c;
    longint                 re_l, im_l;
    logic signed [MW-1:0]   mul_x;
    logic signed [MW-1:0]   mul_y;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   acc_sum;
    logic signed [PW-1:0]   acc_dif;
    logic signed [PW-1:0]   rnd_sum;
    logic signed [PW-1:0]   rnd_dif;
    logic                   sq_start;
    logic [wfms_pkg::RAD_BITS-1:0]  sq_rad;
    logic                   sq_done;
    logic [wfms_pkg::ROOT_BITS-1:0] sq_root;
    logic [63:0]            mag_full;
    logic [15:0]            mag_val;
    logic                   cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono <= 1'b0;
        end else if (cfg_wr && paddr[2] == REG_MONO_MODE) begin
            r_mono <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_MONO_MODE) ? {31'd0, r_mono} : 32'd0;

    // ---------------- input mix ----------------
    assign s_tready = (r_state == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign left_s   = s_tdata[SAMPLE_BITS-1:0];
    assign right_s  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign mix_sum  = (SAMPLE_BITS+1)'(left_s) + (SAMPLE_BITS+1)'(right_s);
    // floor average: arithmetic shift by one
    assign mono_s   = r_mono ? left_s : mix_sum[SAMPLE_BITS:1];

    assign ring_we = (r_state == ST_CLR) || in_acc;
    assign ring_wa = (r_state == ST_CLR) ? r_cnt[LOG2N-1:0] : r_wp;
    assign ring_wd = (r_state == ST_CLR) ? '0 : mono_s;

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wa] <= ring_wd;
        end
        r_ring_q <= r_ring[r_cnt[LOG2N-1:0]];
    end

    // ---------------- butterfly addressing ----------------
    always_comb begin
        for (int b = 0; b < LOG2N; b++) begin
            load_addr[b] = r_cnt[LOG2N-1-b];
        end
    end

    assign hm     = (LOG2N-1)'((1 << r_stage) - 1);
    assign kk     = r_bf & hm;
    assign bf_a   = {r_bf & ~hm, 1'b0} | {1'b0, kk};
    assign bf_b   = bf_a | LOG2N'(1 << r_stage);
    assign tw_idx = (LOG2N-1)'(kk << (SW'(LOG2N - 1) - r_stage));
    assign wc     = TW_COS[tw_idx];
    assign ws     = TW_SIN[tw_idx];

    // magnitude phase reads one bin at the counter
    assign rd_addr_a = (r_state >= ST_MRD) ? r_cnt[LOG2N-1:0] : bf_a;

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            r_work[work_wa] <= work_wd;
        end
        r_rd_a <= r_work[rd_addr_a];
        r_rd_b <= r_work[bf_b];
    end

    assign re_a = r_rd_a[2*WW-1:WW];
    assign im_a = r_rd_a[WW-1:0];
    assign re_b = r_rd_b[2*WW-1:WW];
    assign im_b = r_rd_b[WW-1:0];

    // clamp before squaring
    always_comb begin
        re_l = longint'(re_a);
        im_l = longint'(im_a);
        if (re_l > MAG_CLAMP) re_l = MAG_CLAMP;
        if (re_l < -MAG_CLAMP) re_l = -MAG_CLAMP;
        if (im_l > MAG_CLAMP) im_l = MAG_CLAMP;
        if (im_l < -MAG_CLAMP) im_l = -MAG_CLAMP;
        re_c = MW'(re_l);
        im_c = MW'(im_l);
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            ST_LMUL: begin
                mul_x = MW'(r_ring_q);
                mul_y = MW'(WIN_TAB[r_cnt[LOG2N-1:0]]);
            end
            ST_BM0: begin mul_x = MW'(re_b); mul_y = MW'(wc); end
            ST_BM1: begin mul_x = MW'(im_b); mul_y = MW'(ws); end
            ST_BM2: begin mul_x = MW'(im_b); mul_y = MW'(wc); end
            ST_BM3: begin mul_x = MW'(re_b); mul_y = MW'(ws); end
            ST_MRE: begin mul_x = re_c; mul_y = re_c; end
            ST_MIM: begin mul_x = im_c; mul_y = im_c; end
            default: begin mul_x = '0; mul_y = '0; end
        endcase
    end

    assign prod    = mul_x * mul_y;
    assign acc_sum = r_acc + prod;
    assign acc_dif = r_acc - prod;
    assign rnd_sum = (acc_sum + RND_HALF) >>> 15;
    assign rnd_dif = (acc_dif + RND_HALF) >>> 15;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LMUL: r_acc <= prod;
            ST_BM0:  r_acc <= prod;
            ST_BM1:  r_tr  <= WW'(rnd_sum);
            ST_BM2:  r_acc <= prod;
            ST_BM3:  r_ti  <= WW'(rnd_dif);
            ST_MRE:  r_acc <= prod;
            default: r_acc <= r_acc;
        endcase
    end

    // ---------------- work memory writes ----------------
    always_comb begin
        work_we = 1'b0;
        work_wa = bf_a;
        work_wd = {re_a + r_tr, im_a + r_ti};
        case (r_state)
            ST_LWR: begin
                work_we = 1'b1;
                work_wa = load_addr;
                work_wd = {WW'((r_acc + RND_HALF) >>> 15), {WW{1'b0}}};
            end
            ST_BWA: begin
                work_we = 1'b1;
                work_wa = bf_a;
                work_wd = {re_a + r_tr, im_a + r_ti};
            end
            ST_BWB: begin
                work_we = 1'b1;
                work_wa = bf_b;
                work_wd = {re_a - r_tr, im_a - r_ti};
            end
            default: work_we = 1'b0;
        endcase
    end

    // ---------------- magnitude ----------------
    assign sq_start = (r_state == ST_MIM);
    assign sq_rad   = wfms_pkg::RAD_BITS'(acc_sum) << 6;

    wfms_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // divide by a power of two with round half up, then saturate
    assign mag_full = ((64'(sq_root) << UP) + (64'd1 << (SH - 1))) >> SH;
    assign mag_val  = (r_cnt >= CW'(NUM_BINS)) ? 16'd0 :
                      (mag_full > 64'd65535) ? 16'hFFFF : mag_full[15:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MOUT) begin
            case (r_slot)
                2'd0: r_mag0 <= mag_val;
                2'd1: r_mag1 <= mag_val;
                default: begin
                    r_mout <= {1'b0, mag_val, r_mag1, r_mag0, 7'(r_cnt - CW'(2))};
                    r_last <= (r_cnt + CW'(1) == CW'(SLOTS_END));
                end
            endcase
        end
    end

    assign m_tvalid = (r_state == ST_OUT);
    assign m_tdata  = r_mout;
    assign m_tlast  = r_last;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_wp    = r_wp;
        n_stage = r_stage;
        n_bf    = r_bf;
        n_slot  = r_slot;
        unique case (r_state)
            ST_CLR: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(FFT_POINTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_wp    = r_wp + LOG2N'(1);
                    n_cnt   = '0;
                    n_state = ST_LRD;
                end
            end
            ST_LRD:  n_state = ST_LMUL;
            ST_LMUL: n_state = ST_LWR;
            ST_LWR: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(FFT_POINTS - 1)) begin
                    n_stage = '0;
                    n_bf    = '0;
                    n_state = ST_BRD;
                end else begin
                    n_state = ST_LRD;
                end
            end
            ST_BRD: n_state = ST_BM0;
            ST_BM0: n_state = ST_BM1;
            ST_BM1: n_state = ST_BM2;
            ST_BM2: n_state = ST_BM3;
            ST_BM3: n_state = ST_BWA;
            ST_BWA: n_state = ST_BWB;
            ST_BWB: begin
                n_bf = r_bf + (LOG2N-1)'(1);
                if (r_bf == {(LOG2N-1){1'b1}}) begin
                    if (r_stage == SW'(LOG2N - 1)) begin
                        n_cnt   = '0;
                        n_slot  = '0;
                        n_state = ST_MRD;
                    end else begin
                        n_stage = r_stage + SW'(1);
                        n_state = ST_BRD;
                    end
                end else begin
                    n_state = ST_BRD;
                end
            end
            ST_MRD: n_state = ST_MRE;
            ST_MRE: n_state = ST_MIM;
            ST_MIM: n_state = ST_MSQ;
            ST_MSQ: begin
                if (sq_done) begin
                    n_state = ST_MOUT;
                end
            end
            ST_MOUT: begin
                n_cnt = r_cnt + CW'(1);
                if (r_slot == 2'd2) begin
                    n_slot  = '0;
                    n_state = ST_OUT;
                end else begin
                    n_slot  = r_slot + 2'd1;
                    n_state = ST_MRD;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    n_state = r_last ? ST_IDLE : ST_MRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_cnt   <= '0;
            r_wp    <= '0;
            r_stage <= '0;
            r_bf    <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wp    <= n_wp;
            r_stage <= n_stage;
            r_bf    <= n_bf;
            r_slot  <= n_slot;
        end
    end

endmodule

@@ rtl/wfms_isqrt.sv @@
// Bit-pair iterative integer square root, two radicand bits per cycle.
module wfms_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [wfms_pkg::RAD_BITS-1:0]   i_rad,
    output logic                            o_done,
    output logic [wfms_pkg::ROOT_BITS-1:0]  o_root
);

    logic [wfms_pkg::RAD_BITS-1:0] r_n;
    logic [wfms_pkg::RAD_BITS-1:0] r_res;
    logic [wfms_pkg::RAD_BITS-1:0] r_bit;
    logic                          r_busy;
    logic                          r_done;
    logic [wfms_pkg::RAD_BITS-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == wfms_pkg::RAD_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_rad;
            r_res <= '0;
            r_bit <= wfms_pkg::RAD_BITS'(1) << (wfms_pkg::RAD_BITS - 2);
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[wfms_pkg::ROOT_BITS-1:0];

endmodule

@@ bench/windowed_fft_magnitude_spectrum_top_test.sv @@
// Self-checking bench for the windowed FFT magnitude spectrum block.
module windowed_fft_magnitude_spectrum_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS   = 256;
    localparam int NBINS  = NPTS / 2 + 1;
    localparam int NGRP   = (NBINS + 2) / 3;
    localparam logic [2:0] REG_MONO_ADDR  = 3'd0;   // register 0: mono_mode
    localparam logic [2:0] REG_SPARE_ADDR = 3'd4;   // beyond the register list, must be ignored

    typedef struct {
        logic [6:0]  first_bin;
        logic [15:0] mag_a;
        logic [15:0] mag_b;
        logic [15:0] mag_c;
        logic        last_group;
    } spectrum_group_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // left_sample[15:0], right_sample[31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // first_bin, magnitude_a, magnitude_b, magnitude_c, pad
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    windowed_fft_magnitude_spectrum_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Spectrum predictor: own copy of ring, pointer, mode and tables
    // ---------------------------------------------------------------
    longint            hamming_q15 [NPTS];
    longint            root_cos [NPTS/2];
    longint            root_sin [NPTS/2];
    longint            mono_ring [NPTS];
    int unsigned       ring_wr_ptr;
    bit                mono_sel;
    spectrum_group_t   expected_groups [$];
    stereo_word_t      pending_words [$];
    int                fail_count = 0;
    bit                no_idle = 1'b0;

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Taylor series on [0, pi/2], Q30
    function automatic longint taylor_q30(longint unsigned th, bit want_sin);
        longint unsigned x2, term, d;
        longint sum;
        x2 = (th * th) >> 30;
        term = want_sin ? th : (64'd1 << 30);
        sum = longint'(term);
        for (int k = 1; k <= 10; k++) begin
            d = want_sin ? longint'(2*k) * (2*k + 1) : longint'(2*k - 1) * (2*k);
            term = ((term * x2) >> 30) / d;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return sum;
    endfunction

    // cos/sin of 2*pi*num/den via 32-bit turn fraction and quadrant fold
    task automatic turn_cos_sin(input longint unsigned num, input longint unsigned den,
                                output longint c, output longint s);
        longint unsigned p, q, th;
        longint c0, s0;
        p = ((num << 32) / den) & 64'hFFFF_FFFF;
        q = p >> 30;
        th = ((p & 64'h3FFF_FFFF) * longint'(wfms_pkg::TWO_PI_Q30)) >> 32;
        c0 = taylor_q30(th, 1'b0);
        s0 = taylor_q30(th, 1'b1);
        case (q)
            0: begin c = c0;  s = s0;  end
            1: begin c = -s0; s = c0;  end
            2: begin c = -c0; s = -s0; end
            default: begin c = s0; s = -c0; end
        endcase
    endtask

    task automatic build_coef_tables();
        longint c, s;
        for (int i = 0; i < NPTS; i++) begin
            turn_cos_sin(i, NPTS - 1, c, s);
            hamming_q15[i] = round_shift(wfms_pkg::HAM_A_Q30 * (64'sd1 <<< 30)
                                         - wfms_pkg::HAM_B_Q30 * c, 45);
        end
        for (int i = 0; i < NPTS/2; i++) begin
            turn_cos_sin(i, NPTS, c, s);
            root_cos[i] = round_shift(c, 15);
            root_sin[i] = round_shift(s, 15);
        end
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp28(longint v);
        if (v > (64'sd1 <<< 28)) return 64'sd1 <<< 28;
        if (v < -(64'sd1 <<< 28)) return -(64'sd1 <<< 28);
        return v;
    endfunction

    // Push the 43 groups that one accepted stereo word produces
    task automatic predict_spectrum(input logic [31:0] word);
        longint re [NPTS];
        longint im [NPTS];
        longint lf, rt, tr, ti, wc, ws, t, a2, b2;
        logic [15:0] mags [NGRP*3];
        longint unsigned sq, sr, o;
        int j, half, stp, ia, ib, w;
        spectrum_group_t g;
        lf = longint'(signed'(word[15:0]));
        rt = longint'(signed'(word[31:16]));
        mono_ring[ring_wr_ptr] = mono_sel ? lf : ((lf + rt) >>> 1);
        ring_wr_ptr = (ring_wr_ptr + 1) % NPTS;
        for (int i = 0; i < NPTS; i++) begin
            re[i] = round_shift(mono_ring[i] * hamming_q15[i], 15);
            im[i] = 0;
        end
        for (int i = 0; i < NPTS; i++) begin
            j = 0;
            for (int b = 0; b < 8; b++) j |= ((i >> b) & 1) << (7 - b);
            if (j > i) begin
                t = re[i]; re[i] = re[j]; re[j] = t;
            end
        end
        for (int len = 2; len <= NPTS; len <<= 1) begin
            half = len / 2;
            stp = NPTS / len;
            for (int st = 0; st < NPTS; st += len) begin
                for (int k = 0; k < half; k++) begin
                    ia = st + k;
                    ib = ia + half;
                    w = (k * stp) & (NPTS/2 - 1);
                    wc = root_cos[w];
                    ws = root_sin[w];
                    tr = round_shift(re[ib] * wc + im[ib] * ws, 15);
                    ti = round_shift(im[ib] * wc - re[ib] * ws, 15);
                    re[ib] = re[ia] - tr;
                    im[ib] = im[ia] - ti;
                    re[ia] += tr;
                    im[ia] += ti;
                end
            end
        end
        for (int k = 0; k < NGRP*3; k++) begin
            if (k >= NBINS) begin
                mags[k] = '0;       // slot past the top bin
            end else begin
                a2 = clamp28(re[k]);
                b2 = clamp28(im[k]);
                sq = longint'(a2 * a2) + longint'(b2 * b2);
                sr = int_sqrt(sq << 6);
                o = (sr + 512) / 1024;  // divide by N * 2^(16-14)
                mags[k] = (o > 65535) ? 16'hFFFF : o[15:0];
            end
        end
        for (int gi = 0; gi < NGRP; gi++) begin
            g.first_bin = 7'(3 * gi);
            g.mag_a = mags[3*gi];
            g.mag_b = mags[3*gi + 1];
            g.mag_c = mags[3*gi + 2];
            g.last_group = (gi == NGRP - 1);
            expected_groups.push_back(g);
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: stereo words from the pending queue, random idle bursts
    // ---------------------------------------------------------------
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_spectrum(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                    src_gap <= $urandom_range(1, 13);
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    stereo_word_t sw;
                    sw = pending_words.pop_front();
                    s_tdata <= {sw.right, sw.left};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, field-by-field compare
    // ---------------------------------------------------------------
    int sink_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_groups.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    spectrum_group_t e;
                    e = expected_groups.pop_front();
                    if (m_tdata[6:0] !== e.first_bin) begin
                        $display("%0t: first_bin expected %0d actual %0d",
                                 $time, e.first_bin, m_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_tdata[22:7] !== e.mag_a) begin
                        $display("%0t: magnitude_a (bin %0d) expected %0d actual %0d",
                                 $time, e.first_bin, e.mag_a, m_tdata[22:7]);
                        fail_count++;
                    end
                    if (m_tdata[38:23] !== e.mag_b) begin
                        $display("%0t: magnitude_b (bin %0d) expected %0d actual %0d",
                                 $time, e.first_bin, e.mag_b, m_tdata[38:23]);
                        fail_count++;
                    end
                    if (m_tdata[54:39] !== e.mag_c) begin
                        $display("%0t: magnitude_c (bin %0d) expected %0d actual %0d",
                                 $time, e.first_bin, e.mag_c, m_tdata[54:39]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last_group) begin
                        $display("%0t: last_group (bin %0d) expected %b actual %b",
                                 $time, e.first_bin, e.last_group, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(1, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus sequencing
    // ---------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);   // write lands at this edge
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_MONO_ADDR) mono_sel = data[0];
    endtask

    task automatic add_word(input logic [15:0] l, input logic [15:0] r);
        stereo_word_t sw;
        sw.left = l;
        sw.right = r;
        pending_words.push_back(sw);
    endtask

    // Block between phases: everything sent and every group back
    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_groups.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic add_random(input int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) add_word(16'($urandom), 16'($urandom));
            else if (kind < 8) add_word(16'($signed($urandom_range(0, 511)) - 256),
                                        16'($signed($urandom_range(0, 511)) - 256));
            else if (kind == 8) add_word($urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                                         $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            else add_word(16'h7FFF - 16'($urandom_range(0, 3)), 16'h8000);
        end
    endtask

    initial begin
        ring_wr_ptr = 0;
        mono_sel = 1'b0;
        for (int i = 0; i < NPTS; i++) mono_ring[i] = 0;
        build_coef_tables();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, stereo average: extremes, zeros, odd sums that floor
        add_word(16'h0000, 16'h0000);
        add_word(16'h7FFF, 16'h7FFF);
        add_word(16'h8000, 16'h8000);
        add_word(16'h7FFF, 16'h8000);
        add_word(16'hFFFF, 16'h0000);
        add_word(16'h0001, 16'h0000);
        add_word(16'h8000, 16'h7FFF);
        add_word(16'h5555, 16'hAAAA);
        drain();

        // Mono mode: right channel must be ignored
        apb_write(REG_MONO_ADDR, 32'h0000_0001);
        add_word(16'h7FFF, 16'h8000);
        add_word(16'h8000, 16'h7FFF);
        add_word(16'h0000, 16'h7FFF);
        add_word(16'hAAAA, 16'h5555);
        add_word(16'h0001, 16'hFFFF);
        drain();

        // Upper bits set but bit 0 clear selects averaging; spare address is a no-op
        apb_write(REG_MONO_ADDR, 32'hFFFF_FFFE);
        apb_write(REG_SPARE_ADDR, 32'h0000_0001);
        add_word(16'h7FFF, 16'h8000);
        add_word(16'h1234, 16'hFEDC);
        add_word(16'h8000, 16'hFFFF);
        drain();

        // Random phases, alternating mode
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(REG_MONO_ADDR, {$urandom} & 32'hFFFF_FFFE | 32'(ph % 2));
            add_random(24);
            drain();
        end
        no_idle = 1'b1;
        apb_write(REG_MONO_ADDR, 32'h0000_0000);
        add_random(24);
        drain();

        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Timeout for roughly 140 words, with margin several times over
    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
